// File: hdl/pfa_pkg.sv
// shared types, constants and helpers for the per-cpu page allocator
package pfa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 56;
  localparam int CPU_IN_W   = 3;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int OPW        = ADDR_W + 1;
  localparam int LINK_W     = PG_W + 1;

  typedef logic [OPW-1:0]    op_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PG_W-1:0]   pg_t;
  typedef logic [CPU_W-1:0]  cpu_t;
  typedef logic [OPW-PAGE_SHIFT-1:0] pgnum_t;

  localparam pgnum_t NUM_PAGES_V = pgnum_t'(NUM_PAGES);
  localparam op_t    PAGE_MASK   = op_t'(PAGE_BYTES - 1);

  // register index, taken from paddr bit 3
  localparam logic REG_START = 1'b0;
  localparam logic REG_TOP   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_CHK_LO,
    S_CHK_HI,
    S_OFFSET,
    S_PUSH,
    S_PICK,
    S_READ,
    S_POP,
    S_GRANT,
    S_DONE
  } state_e;

  // cpu index folded onto the cpus that exist
  function automatic cpu_t cpu_wrap(logic [CPU_IN_W-1:0] v);
    cpu_t r;
    r = '0;
    for (int i = 0; i < (1 << CPU_IN_W); i++) begin
      if (v == CPU_IN_W'(i)) begin
        r = cpu_t'(i % NUM_CPUS);
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/pfa_ram.sv
// generic single-write, single-read ram with registered read data
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/pfa_alu.sv
// shared adder/subtractor used for every address compare and sum
module pfa_alu (
  input  pfa_pkg::op_t a_i,
  input  pfa_pkg::op_t b_i,
  input  logic         sub_i,
  output pfa_pkg::op_t sum_o,
  output logic         carry_o
);

  pfa_pkg::op_t b_eff;
  logic [pfa_pkg::OPW:0] full;

  always_comb begin
    b_eff = sub_i ? ~b_i : b_i;
    full  = {1'b0, a_i} + {1'b0, b_eff} + {{pfa_pkg::OPW{1'b0}}, sub_i};
  end

  // on subtract, carry set means a >= b
  assign sum_o   = full[pfa_pkg::OPW-1:0];
  assign carry_o = full[pfa_pkg::OPW];

endmodule

// File: hdl/per_cpu_page_free_list_allocator_core.sv
// per-cpu free list page allocator: sequencer, head registers and link store
// one item at a time: a new item is accepted only in idle, once the last result has left done;
// the single 57-bit adder is stepped through the base, bounds and offset checks,
//   and a pop waits on the registered link-store read; out of memory skips read, pop and grant
// reset: all lists empty at once through per-cpu valid bits; the link store is not cleared
// and needs no clearing pass, so the block is ready for an item as soon as reset is released
module per_cpu_page_free_list_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [2:0]                  cpu_index_i,
  input  logic [pfa_pkg::ADDR_W-1:0]  page_address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfa_pkg::ADDR_W-1:0]  granted_address_o,
  output logic [1:0]                  status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  pfa_pkg::state_e  state_q, state_d;
  pfa_pkg::addr_t   start_q, top_q;
  logic             head_ok_q [pfa_pkg::NUM_CPUS];
  pfa_pkg::pg_t     head_idx_q [pfa_pkg::NUM_CPUS];
  pfa_pkg::func_e   func_q;
  pfa_pkg::cpu_t    sel_q;
  pfa_pkg::addr_t   addr_q;
  pfa_pkg::op_t     base_q;
  pfa_pkg::op_t     off_q;
  pfa_pkg::pg_t     page_q;
  pfa_pkg::status_e res_st_q;
  pfa_pkg::addr_t   res_addr_q;
  logic             out_valid_q;
  pfa_pkg::addr_t   out_addr_q;
  pfa_pkg::status_e out_st_q;

  pfa_pkg::op_t     alu_a, alu_b, alu_sum;
  logic             alu_sub, alu_carry;
  logic             ram_we;
  pfa_pkg::pg_t     ram_waddr;
  logic [pfa_pkg::LINK_W-1:0] ram_wdata, ram_rdata;

  logic             accept, can_out, own_ok, any_ok, push_ok, cfg_wr;
  pfa_pkg::cpu_t    pick;

  pfa_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  pfa_ram #(
    .WIDTH (pfa_pkg::LINK_W),
    .DEPTH (pfa_pkg::NUM_PAGES)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_idx_q[sel_q]),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == pfa_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_out    = !out_valid_q || out_ready_i;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  always_comb begin
    own_ok = head_ok_q[sel_q];
    any_ok = 1'b0;
    pick   = '0;
    for (int i = pfa_pkg::NUM_CPUS - 1; i >= 0; i--) begin
      if (head_ok_q[i]) begin
        any_ok = 1'b1;
        pick   = pfa_pkg::cpu_t'(i);
      end
    end
  end

  // page number must lie below the page count
  assign push_ok = (res_st_q == pfa_pkg::ST_OK) &&
                   (off_q[pfa_pkg::OPW-1:pfa_pkg::PAGE_SHIFT] < pfa_pkg::NUM_PAGES_V);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::S_IDLE:   if (accept) state_d = pfa_pkg::S_BASE;
      pfa_pkg::S_BASE: begin
        state_d = (func_q == pfa_pkg::FUNC_FREE) ? pfa_pkg::S_CHK_LO : pfa_pkg::S_PICK;
      end
      pfa_pkg::S_CHK_LO: state_d = pfa_pkg::S_CHK_HI;
      pfa_pkg::S_CHK_HI: state_d = pfa_pkg::S_OFFSET;
      pfa_pkg::S_OFFSET: state_d = pfa_pkg::S_PUSH;
      pfa_pkg::S_PUSH:   state_d = pfa_pkg::S_DONE;
      pfa_pkg::S_PICK:   state_d = any_ok ? pfa_pkg::S_READ : pfa_pkg::S_DONE;
      pfa_pkg::S_READ:   state_d = pfa_pkg::S_POP;
      pfa_pkg::S_POP:    state_d = pfa_pkg::S_GRANT;
      pfa_pkg::S_GRANT:  state_d = pfa_pkg::S_DONE;
      pfa_pkg::S_DONE:   if (can_out) state_d = pfa_pkg::S_IDLE;
      default:           state_d = pfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    alu_a     = pfa_pkg::op_t'(addr_q);
    alu_b     = '0;
    alu_sub   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = off_q[pfa_pkg::PG_W+pfa_pkg::PAGE_SHIFT-1:pfa_pkg::PAGE_SHIFT];
    ram_wdata = {head_ok_q[sel_q], head_idx_q[sel_q]};
    case (state_q)
      pfa_pkg::S_BASE: begin
        alu_a = pfa_pkg::op_t'(start_q);
        alu_b = pfa_pkg::PAGE_MASK;
      end
      pfa_pkg::S_CHK_LO: begin
        alu_b   = pfa_pkg::op_t'(start_q);
        alu_sub = 1'b1;
      end
      pfa_pkg::S_CHK_HI: begin
        alu_b   = pfa_pkg::op_t'(top_q);
        alu_sub = 1'b1;
      end
      pfa_pkg::S_OFFSET: begin
        alu_b   = base_q;
        alu_sub = 1'b1;
      end
      pfa_pkg::S_PUSH:   ram_we = push_ok;
      pfa_pkg::S_GRANT: begin
        alu_a = base_q;
        alu_b = pfa_pkg::op_t'({page_q, {pfa_pkg::PAGE_SHIFT{1'b0}}});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= pfa_pkg::addr_t'(64'd2147483648);
      top_q       <= pfa_pkg::addr_t'(64'd2281701376);
      for (int i = 0; i < pfa_pkg::NUM_CPUS; i++) begin
        head_ok_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == pfa_pkg::S_DONE && can_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3])
          pfa_pkg::REG_START: start_q <= pwdata[pfa_pkg::ADDR_W-1:0];
          pfa_pkg::REG_TOP:   top_q   <= pwdata[pfa_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (state_q == pfa_pkg::S_PUSH && push_ok) begin
        head_ok_q[sel_q] <= 1'b1;
      end else if (state_q == pfa_pkg::S_POP) begin
        head_ok_q[sel_q] <= ram_rdata[pfa_pkg::PG_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pfa_pkg::S_IDLE: begin
        if (accept) begin
          func_q     <= pfa_pkg::func_e'(func_i);
          sel_q      <= pfa_pkg::cpu_wrap(cpu_index_i);
          addr_q     <= page_address_i;
          res_st_q   <= pfa_pkg::ST_OK;
          res_addr_q <= '0;
        end
      end
      pfa_pkg::S_BASE:   base_q <= alu_sum & ~pfa_pkg::PAGE_MASK;
      pfa_pkg::S_CHK_LO: begin
        if (!alu_carry || (addr_q[pfa_pkg::PAGE_SHIFT-1:0] != '0)) begin
          res_st_q <= pfa_pkg::ST_BAD_FREE;
        end
      end
      pfa_pkg::S_CHK_HI: if (alu_carry) res_st_q <= pfa_pkg::ST_BAD_FREE;
      pfa_pkg::S_OFFSET: begin
        off_q <= alu_sum;
        if (!alu_carry) res_st_q <= pfa_pkg::ST_BAD_FREE;
      end
      pfa_pkg::S_PUSH: begin
        if (push_ok) begin
          head_idx_q[sel_q] <= ram_waddr;
        end else begin
          res_st_q <= pfa_pkg::ST_BAD_FREE;
        end
      end
      pfa_pkg::S_PICK: begin
        // own list first, else lowest non-empty list
        if (!any_ok) begin
          res_st_q <= pfa_pkg::ST_OOM;
        end else if (!own_ok) begin
          sel_q <= pick;
        end
      end
      pfa_pkg::S_READ:  page_q <= head_idx_q[sel_q];
      pfa_pkg::S_POP:   head_idx_q[sel_q] <= ram_rdata[pfa_pkg::PG_W-1:0];
      pfa_pkg::S_GRANT: res_addr_q <= alu_sum[pfa_pkg::ADDR_W-1:0];
      pfa_pkg::S_DONE: begin
        if (can_out) begin
          out_addr_q <= res_addr_q;
          out_st_q   <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (paddr[3])
      pfa_pkg::REG_START: prdata = 64'(start_q);
      pfa_pkg::REG_TOP:   prdata = 64'(top_q);
      default:            prdata = '0;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_st_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("allocator ready again right after taking an item");

  a_no_false_oom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfa_pkg::S_PICK) && any_ok |=> (state_q == pfa_pkg::S_READ))
    else $error("allocate skipped a non-empty list");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pfa_pkg::ST_OK) |-> (granted_address_o == '0))
    else $error("nonzero address with an error status");
`endif

endmodule

// File: bench/tb_top.sv
// testbench for the per-cpu page allocator: directed table, random traffic, predictor check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int N_DIRECTED  = 25;
  localparam addr_t RB       = 56'h8000_0000;
  localparam addr_t RB_LAST  = 56'h87FF_F000;
  localparam addr_t RB_TOP   = 56'h8800_0000;
  localparam addr_t ALL_ONES = {ADDR_W{1'b1}};

  typedef struct {
    addr_t   addr;
    status_e st;
  } page_result_t;

  typedef struct packed {
    func_e       fn;
    logic [2:0]  cpu;
    addr_t       addr;
    logic        known;
    addr_t       exp_addr;
    status_e     exp_st;
  } dir_row_t;

  // rows with known set carry a typed result that replaces the predicted one; all rows update the predictor
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{FUNC_ALLOC, 3'd0, 56'h0,            1'b1, 56'h0,   ST_OOM},
    '{FUNC_ALLOC, 3'd7, ALL_ONES,         1'b1, 56'h0,   ST_OOM},
    '{FUNC_FREE,  3'd0, RB,               1'b1, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd3, RB_LAST,          1'b1, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd4, RB + 56'h1,       1'b1, 56'h0,   ST_BAD_FREE},
    '{FUNC_FREE,  3'd4, RB - 56'h1000,    1'b1, 56'h0,   ST_BAD_FREE},
    '{FUNC_FREE,  3'd4, RB_TOP,           1'b1, 56'h0,   ST_BAD_FREE},
    '{FUNC_FREE,  3'd5, ALL_ONES,         1'b1, 56'h0,   ST_BAD_FREE},
    '{FUNC_FREE,  3'd6, 56'h0,            1'b1, 56'h0,   ST_BAD_FREE},
    '{FUNC_ALLOC, 3'd0, 56'h0,            1'b1, RB,      ST_OK},
    '{FUNC_ALLOC, 3'd5, 56'h0,            1'b1, RB_LAST, ST_OK},
    '{FUNC_ALLOC, 3'd1, 56'h0,            1'b1, 56'h0,   ST_OOM},
    '{FUNC_FREE,  3'd2, RB + 56'h1000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd2, RB + 56'h2000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd6, RB + 56'h3000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd2, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd4, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd4, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd1, RB + 56'h4000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd1, RB + 56'h4000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd1, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_FREE,  3'd2, RB + 56'h4000,    1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd1, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd2, 56'h0,            1'b0, 56'h0,   ST_OK},
    '{FUNC_ALLOC, 3'd3, 56'h0,            1'b0, 56'h0,   ST_OK}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [2:0]  cpu_index_i;
  addr_t       page_address_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  addr_t       granted_address_o;
  logic [1:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  per_cpu_page_free_list_allocator_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .cpu_index_i       (cpu_index_i),
    .page_address_i    (page_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: free lists and region registers as the block should hold them
  pg_t   head_pg  [NUM_CPUS];
  bit    head_vld [NUM_CPUS];
  pg_t   link_pg  [NUM_PAGES];
  bit    link_vld [NUM_PAGES];
  addr_t reg_start = 56'h8000_0000;
  addr_t reg_top   = 56'h8800_0000;

  page_result_t expected_results[$];
  addr_t        granted_pages[$];
  int           errors;
  int           cycle_count;
  int           stall_left;
  bit           idling_on;
  bit           typed_known;
  addr_t        typed_addr;
  status_e      typed_st;

  function automatic logic [63:0] page_base();
    return ((64'(reg_start) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)) * 64'(PAGE_BYTES);
  endfunction

  function automatic bit take_page(input int cpu, output pg_t pg);
    if (!head_vld[cpu]) return 1'b0;
    pg = head_pg[cpu];
    head_pg[cpu]  = link_pg[pg];
    head_vld[cpu] = link_vld[pg];
    return 1'b1;
  endfunction

  function automatic page_result_t predict_request(input func_e fn, input logic [2:0] cpu_raw,
                                                   input addr_t a);
    page_result_t r;
    logic [63:0]  base;
    logic [63:0]  pgn;
    pg_t          pg;
    int           cpu;
    bit           got;
    r.addr = '0;
    r.st   = ST_OK;
    cpu    = int'(cpu_raw) % NUM_CPUS;
    base   = page_base();
    if (fn == FUNC_FREE) begin
      if (a[PAGE_SHIFT-1:0] != '0 || a < reg_start || a >= reg_top || 64'(a) < base) begin
        r.st = ST_BAD_FREE;
      end else begin
        pgn = (64'(a) - base) >> PAGE_SHIFT;
        if (pgn >= 64'(NUM_PAGES)) begin
          r.st = ST_BAD_FREE;
        end else begin
          pg = pg_t'(pgn);
          link_pg[pg]   = head_pg[cpu];
          link_vld[pg]  = head_vld[cpu];
          head_pg[cpu]  = pg;
          head_vld[cpu] = 1'b1;
        end
      end
    end else begin
      got = take_page(cpu, pg);
      // steal from the lowest-numbered other cpu that has a page
      for (int c = 0; !got && c < NUM_CPUS; c++) begin
        if (c != cpu) got = take_page(c, pg);
      end
      if (!got) r.st = ST_OOM;
      else r.addr = addr_t'(base + (64'(pg) << PAGE_SHIFT));
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    page_result_t want;
    page_result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: granted_address %h status %0d",
                 granted_address_o, status_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (granted_address_o !== want.addr) begin
            $error("granted_address: expected %h, actual %h", want.addr, granted_address_o);
            errors++;
          end
          if (status_o !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        got = predict_request(func_e'(func_i), cpu_index_i, page_address_i);
        if (func_i == FUNC_ALLOC && got.st == ST_OK) granted_pages.push_back(got.addr);
        if (typed_known) begin
          got.addr = typed_addr;
          got.st   = typed_st;
        end
        expected_results.push_back(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts of random length while idling is on
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idling_on && rst_ni && $urandom_range(0, 99) < 12) begin
      stall_left = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(input logic idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_START) reg_start = addr_t'(val);
    else reg_top = addr_t'(val);
  endtask

  // optional sender gap, returns at the falling edge where the next item goes out
  task automatic wait_slot();
    int gap;
    gap = (idling_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic drive_request(input func_e fn, input logic [2:0] cpu, input addr_t a,
                               input bit known, input addr_t ka, input status_e ks);
    typed_known = known;
    typed_addr  = ka;
    typed_st    = ks;
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    cpu_index_i    <= cpu;
    page_address_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input addr_t start_v, input addr_t top_v, input int n_items,
                           input bit allow_idle);
    logic [63:0] base;
    logic [63:0] span;
    int          avail;
    int          fresh_page;
    int          r;
    int          j;
    bit          draining;
    func_e       fn;
    logic [2:0]  cpu;
    addr_t       a;
    addr_t       last_freed;
    drain_results();
    write_reg(REG_START, 64'(start_v));
    write_reg(REG_TOP, 64'(top_v));
    base = page_base();
    span = (64'(reg_top) > base) ? (64'(reg_top) - base) >> PAGE_SHIFT : 64'd0;
    avail = (span > 64'(NUM_PAGES)) ? NUM_PAGES : int'(span);
    fresh_page = 0;
    last_freed = addr_t'(base);
    draining = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      // switch between fill and drain, and between idling and full rate
      if (k % 40 == 0) begin
        idling_on = allow_idle && ($urandom_range(0, 3) != 0);
        draining  = $urandom_range(0, 1);
      end
      wait_slot();
      cpu = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < (draining ? 65 : 35)) begin
        fn = FUNC_ALLOC;
        a  = addr_t'({$urandom, $urandom});
      end else begin
        fn = FUNC_FREE;
        r  = $urandom_range(0, 99);
        if (r < 45 && granted_pages.size() > 0) begin
          j = $urandom_range(0, granted_pages.size() - 1);
          a = granted_pages[j];
          granted_pages.delete(j);
        end else if (r < 80 && avail > 0) begin
          fresh_page = (fresh_page + $urandom_range(1, 3)) % avail;
          a = addr_t'(base + (64'(fresh_page) << PAGE_SHIFT));
        end else if (r < 85) begin
          a = last_freed;
        end else begin
          case ($urandom_range(0, 4))
            0: a = last_freed + addr_t'($urandom_range(1, PAGE_BYTES - 1));
            1: a = (reg_start != '0) ?
                   addr_t'({$urandom, $urandom} % 64'(reg_start)) & ~addr_t'(PAGE_BYTES - 1) :
                   '0;
            2: a = addr_t'(((64'(reg_top) + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1)) +
                           64'($urandom_range(0, 3)) * 64'(PAGE_BYTES));
            3: a = addr_t'({$urandom, $urandom});
            default: a = addr_t'(base + (64'(NUM_PAGES + $urandom_range(0, 63)) << PAGE_SHIFT));
          endcase
        end
        last_freed = a;
      end
      drive_request(fn, cpu, a, 1'b0, '0, ST_OK);
    end
  endtask

  initial begin
    addr_t odd_start;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = 1'b0;
    cpu_index_i    = '0;
    page_address_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    errors         = 0;
    cycle_count    = 0;
    stall_left     = 0;
    idling_on      = 1'b1;
    typed_known    = 1'b0;
    typed_addr     = '0;
    typed_st       = ST_OK;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      wait_slot();
      drive_request(DIRECTED[i].fn, DIRECTED[i].cpu, DIRECTED[i].addr, DIRECTED[i].known,
                    DIRECTED[i].exp_addr, DIRECTED[i].exp_st);
    end

    odd_start = (addr_t'({$urandom, $urandom}) & 56'h00_FFFF_FFFF_F000) |
                addr_t'($urandom_range(1, PAGE_BYTES - 1));
    run_phase(RB, RB_TOP, 350, 1'b1);
    // whole address space, so page numbers past the store are reachable
    run_phase('0, ALL_ONES, 250, 1'b1);
    // start at the very top: every free is rejected, granted addresses wrap
    run_phase(ALL_ONES, ALL_ONES, 100, 1'b1);
    run_phase(odd_start,
              odd_start + addr_t'(PAGE_BYTES) + addr_t'(64'($urandom_range(20000, 40000)) << 12),
              250, 1'b1);
    // tiny region: frequent out of memory and double frees
    run_phase(56'h1234_5000, 56'h1235_5000, 150, 1'b1);
    run_phase(RB, RB_TOP, 200, 1'b0);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
